[hdl/ast_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types and character constants for the assembly source tokenizer.
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int LINE_W      = 16;
  localparam int OFFSET_W    = 20;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_DIGIT9 = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UPPERA = 8'h41;
  localparam logic [7:0] CH_UPPERF = 8'h46;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LOWERA = 8'h61;
  localparam logic [7:0] CH_LOWERF = 8'h66;
  localparam logic [7:0] CH_LOWERX = 8'h78;

  typedef enum logic [3:0] {
    K_NEWLINE  = 4'd0,
    K_COMMA    = 4'd1,
    K_COLON    = 4'd2,
    K_LBRACKET = 4'd3,
    K_RBRACKET = 4'd4,
    K_NUMBER   = 4'd5,
    K_IDENT    = 4'd6,
    K_END      = 4'd7,
    K_ERROR    = 4'd8
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [LINE_W-1:0]    line;
    logic [LINE_W-1:0]    column;
    logic [OFFSET_W-1:0]  offset;
    logic [LINE_W-1:0]    length;
    logic                 hex;
  } token_t;

  // Up to three tokens caused by one source byte, emitted from slot 0 upward.
  typedef struct packed {
    logic [2:0]           valid;
    token_t [2:0]         tok;
  } bundle_t;

endpackage : ast_pkg
`default_nettype wire

[hdl/ast_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ast_front
// Scanner front end: classifies each byte, tracks position and open-token
// state, and builds the bundle of tokens that the byte causes.
// ----------------------------------------------------------------------------
module ast_front
  import ast_pkg::*;
#(
  parameter int OFFSET_BITS = 20,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_byte,
  input  wire logic       is_final,
  input  wire logic       space,
  output logic            push,
  output bundle_t         bundle
);

  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_ZERO, M_DEC, M_HEX, M_IDENT, M_DROP
  } mode_t;

  typedef logic [COUNT_BITS-1:0]  cnt_t;
  typedef logic [OFFSET_BITS-1:0] off_t;

  mode_t mode, mode_next;
  cnt_t  line_count, line_next;
  cnt_t  column_count, column_next;
  off_t  byte_offset, offset_next;
  cnt_t  start_line, start_line_next;
  cnt_t  start_column, start_column_next;
  off_t  start_offset, start_offset_next;
  cnt_t  token_bytes, token_bytes_next;

  logic  accept;
  logic  do_idle;
  logic  errored;
  logic  is_dec, is_hex, ends_number, ends_ident;
  logic  c_nl, c_cr, c_sp, c_tab, c_semi, c_comma, c_colon, c_lbr, c_rbr;

  function automatic cnt_t inc_cnt(input cnt_t v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic off_t inc_off(input off_t v);
    return (v == {OFFSET_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic token_t mk_tok(input kind_t k, input cnt_t ln, input cnt_t col,
                                    input off_t off, input cnt_t len, input logic hx);
    token_t t;
    t.kind   = k;
    t.line   = LINE_W'(ln);
    t.column = LINE_W'(col);
    t.offset = OFFSET_W'(off);
    t.length = LINE_W'(len);
    t.hex    = hx;
    return t;
  endfunction

  assign in_ready = space;
  assign accept   = in_valid && space;
  assign push     = accept && (bundle.valid != 3'b000);

  assign c_nl    = (char_byte == CH_NL);
  assign c_cr    = (char_byte == CH_CR);
  assign c_sp    = (char_byte == CH_SPACE);
  assign c_tab   = (char_byte == CH_TAB);
  assign c_semi  = (char_byte == CH_SEMI);
  assign c_comma = (char_byte == CH_COMMA);
  assign c_colon = (char_byte == CH_COLON);
  assign c_lbr   = (char_byte == CH_LBRACK);
  assign c_rbr   = (char_byte == CH_RBRACK);

  assign is_dec = (char_byte >= CH_DIGIT0) && (char_byte <= CH_DIGIT9);
  assign is_hex = is_dec || ((char_byte >= CH_LOWERA) && (char_byte <= CH_LOWERF))
                  || ((char_byte >= CH_UPPERA) && (char_byte <= CH_UPPERF));
  assign ends_number = c_sp || c_nl || c_cr || c_colon || c_comma || c_semi || c_rbr;
  assign ends_ident  = ends_number || c_tab || c_lbr;

  always_comb begin
    mode_next         = mode;
    line_next         = line_count;
    column_next       = column_count;
    offset_next       = byte_offset;
    start_line_next   = start_line;
    start_column_next = start_column;
    start_offset_next = start_offset;
    token_bytes_next  = token_bytes;
    bundle            = '0;
    do_idle           = 1'b0;
    errored           = 1'b0;

    unique case (mode)
      M_COMMENT: begin
        if (c_nl) begin
          mode_next = M_IDLE;
          do_idle   = 1'b1;
        end else begin
          offset_next = inc_off(byte_offset);
          column_next = inc_cnt(column_count);
        end
      end
      M_ZERO, M_DEC, M_HEX: begin
        if (ends_number) begin
          bundle.valid[0] = 1'b1;
          bundle.tok[0]   = mk_tok(K_NUMBER, start_line, start_column, start_offset,
                                   token_bytes, mode == M_HEX);
          mode_next = M_IDLE;
          do_idle   = 1'b1;
        end else if (mode == M_ZERO && char_byte == CH_LOWERX && !is_final) begin
          token_bytes_next = inc_cnt(token_bytes);
          mode_next        = M_HEX;
          offset_next      = inc_off(byte_offset);
          column_next      = inc_cnt(column_count);
        end else if ((mode == M_HEX) ? is_hex : is_dec) begin
          token_bytes_next = inc_cnt(token_bytes);
          if (mode == M_ZERO) begin
            mode_next = M_DEC;
          end
          offset_next = inc_off(byte_offset);
          column_next = inc_cnt(column_count);
        end else begin
          token_bytes_next = inc_cnt(token_bytes);
          bundle.valid[0]  = 1'b1;
          bundle.tok[0]    = mk_tok(K_ERROR, start_line, start_column, start_offset,
                                    token_bytes_next, mode == M_HEX);
          mode_next = M_DROP;
          errored   = 1'b1;
        end
      end
      M_IDENT: begin
        if (ends_ident) begin
          bundle.valid[0] = 1'b1;
          bundle.tok[0]   = mk_tok(K_IDENT, start_line, start_column, start_offset,
                                   token_bytes, 1'b0);
          mode_next = M_IDLE;
          do_idle   = 1'b1;
        end else begin
          token_bytes_next = inc_cnt(token_bytes);
          offset_next      = inc_off(byte_offset);
          column_next      = inc_cnt(column_count);
        end
      end
      M_DROP: begin
      end
      default: begin
        mode_next = M_IDLE;
        do_idle   = 1'b1;
      end
    endcase

    if (do_idle) begin
      priority if (c_nl) begin
        bundle.valid[1] = 1'b1;
        bundle.tok[1]   = mk_tok(K_NEWLINE, line_count, column_count, byte_offset,
                                 cnt_t'(1), 1'b0);
        offset_next = inc_off(byte_offset);
        line_next   = inc_cnt(line_count);
        column_next = cnt_t'(1);
      end else if (c_cr) begin
        offset_next = inc_off(byte_offset);
      end else if (c_sp || c_tab) begin
        offset_next = inc_off(byte_offset);
        column_next = inc_cnt(column_count);
      end else if (c_semi) begin
        mode_next   = M_COMMENT;
        offset_next = inc_off(byte_offset);
        column_next = inc_cnt(column_count);
      end else if (c_comma || c_colon || c_lbr || c_rbr) begin
        bundle.valid[1] = 1'b1;
        priority if (c_comma) begin
          bundle.tok[1] = mk_tok(K_COMMA, line_count, column_count, byte_offset,
                                 cnt_t'(1), 1'b0);
        end else if (c_colon) begin
          bundle.tok[1] = mk_tok(K_COLON, line_count, column_count, byte_offset,
                                 cnt_t'(1), 1'b0);
        end else if (c_lbr) begin
          bundle.tok[1] = mk_tok(K_LBRACKET, line_count, column_count, byte_offset,
                                 cnt_t'(1), 1'b0);
        end else begin
          bundle.tok[1] = mk_tok(K_RBRACKET, line_count, column_count, byte_offset,
                                 cnt_t'(1), 1'b0);
        end
        offset_next = inc_off(byte_offset);
        column_next = inc_cnt(column_count);
      end else begin
        start_line_next   = line_count;
        start_column_next = column_count;
        start_offset_next = byte_offset;
        token_bytes_next  = cnt_t'(1);
        mode_next         = is_dec ? ((char_byte == CH_DIGIT0) ? M_ZERO : M_DEC) : M_IDENT;
        offset_next       = inc_off(byte_offset);
        column_next       = inc_cnt(column_count);
      end
    end

    // Final byte rewinds; if error-free, it closes open tokens and adds END.
    if (is_final) begin
      if (!errored && mode_next != M_DROP) begin
        if (mode_next == M_ZERO || mode_next == M_DEC || mode_next == M_HEX) begin
          bundle.valid[0] = 1'b1;
          bundle.tok[0]   = mk_tok(K_NUMBER, start_line_next, start_column_next,
                                   start_offset_next, token_bytes_next, mode_next == M_HEX);
        end else if (mode_next == M_IDENT) begin
          bundle.valid[0] = 1'b1;
          bundle.tok[0]   = mk_tok(K_IDENT, start_line_next, start_column_next,
                                   start_offset_next, token_bytes_next, 1'b0);
        end
        bundle.valid[2] = 1'b1;
        bundle.tok[2]   = mk_tok(K_END, line_next, column_next, offset_next,
                                 cnt_t'(0), 1'b0);
      end
      mode_next         = M_IDLE;
      line_next         = cnt_t'(1);
      column_next       = cnt_t'(1);
      offset_next       = '0;
      start_line_next   = cnt_t'(1);
      start_column_next = cnt_t'(1);
      start_offset_next = '0;
      token_bytes_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      line_count   <= cnt_t'(1);
      column_count <= cnt_t'(1);
      byte_offset  <= '0;
      start_line   <= cnt_t'(1);
      start_column <= cnt_t'(1);
      start_offset <= '0;
      token_bytes  <= '0;
    end else if (accept) begin
      mode         <= mode_next;
      line_count   <= line_next;
      column_count <= column_next;
      byte_offset  <= offset_next;
      start_line   <= start_line_next;
      start_column <= start_column_next;
      start_offset <= start_offset_next;
      token_bytes  <= token_bytes_next;
    end
  end

endmodule : ast_front
`default_nettype wire

[hdl/ast_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ast_queue
// Short first-in first-out queue of token bundles between front and back.
// ----------------------------------------------------------------------------
module ast_queue
  import ast_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t wdata,
  input  wire logic    pop,
  output bundle_t      rdata,
  output logic         not_empty,
  output logic         not_full
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  bundle_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [CW-1:0]         count;

  assign not_empty = (count != CW'(0));
  assign not_full  = (count != CW'(QUEUE_DEPTH));
  assign rdata     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule : ast_queue
`default_nettype wire

[hdl/ast_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ast_back
// Emitter back end: walks the valid slots of the head bundle, one token per
// output word, and marks the last token of each bundle.
// ----------------------------------------------------------------------------
module ast_back
  import ast_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire bundle_t head,
  input  wire logic    head_valid,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output token_t       out_tok,
  output logic         out_last
);

  logic [2:0] done;
  logic [2:0] remaining;
  logic [2:0] sel;

  assign remaining = head.valid & ~done;
  assign sel       = remaining & (~remaining + 3'd1);
  assign out_last  = ((remaining & ~sel) == 3'b000);
  assign out_valid = head_valid;
  assign pop       = out_valid && out_ready && out_last;

  always_comb begin
    priority if (sel[0]) begin
      out_tok = head.tok[0];
    end else if (sel[1]) begin
      out_tok = head.tok[1];
    end else begin
      out_tok = head.tok[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (out_valid && out_ready) begin
      done <= out_last ? 3'b000 : (done | sel);
    end
  end

endmodule : ast_back
`default_nettype wire

[hdl/assembly_source_tokenizer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// assembly_source_tokenizer_core
// Streaming lexer for assembly text: one byte in, zero to three tokens out.
//
// The input stream carries one source byte per word in s_axis_tdata, with
// s_axis_tlast marking the last byte of a text. The output stream carries
// one token per word: kind and hex flag in m_axis_tuser, position and length
// in m_axis_tdata, and m_axis_tlast on the last token caused by a byte.
// A byte is classified in the cycle it is accepted; its tokens enter a
// four-entry bundle queue of registers, whose head bundle drives the output.
// While the queue has room the block takes one byte per cycle; a byte that
// causes k tokens yields k words, so sustained rate is one word per cycle on
// whichever side is busier. When the receiver stalls, bytes keep flowing in
// until the queue holds four unsent bundles, then s_axis_tready drops.
// Reset clears position counters to line 1, column 1, offset 0, and empties
// the queue. The last byte of a text also restores the position counters.
// ----------------------------------------------------------------------------
module assembly_source_tokenizer_core
  import ast_pkg::*;
#(
  parameter int OFFSET_BITS = 20,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // char_byte
  input  wire logic        s_axis_tlast,   // is_final
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // start_line [15:0], start_column [31:16], start_offset [51:32],
  // token_length [67:52], zero fill [71:68]
  output logic [71:0]      m_axis_tdata,
  output logic [4:0]       m_axis_tuser,   // token_kind [3:0], number_is_hex [4]
  output logic             m_axis_tlast    // final_result
);

  logic    q_push, q_pop, q_not_empty, q_not_full;
  bundle_t q_wdata, q_rdata;
  token_t  tok;

  ast_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .char_byte (s_axis_tdata),
    .is_final  (s_axis_tlast),
    .space     (q_not_full),
    .push      (q_push),
    .bundle    (q_wdata)
  );

  ast_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty),
    .not_full  (q_not_full)
  );

  ast_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_rdata),
    .head_valid (q_not_empty),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_tok    (tok),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, tok.length, tok.offset, tok.column, tok.line};
  assign m_axis_tuser = {tok.hex, tok.kind};

  // The end token always closes the tokens of its byte.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[3:0] == K_END) |-> m_axis_tlast)
    else $error("end token not marked last");

  // The end token carries no text.
  a_end_no_length: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[3:0] == K_END) |-> (m_axis_tdata[67:52] == 16'd0))
    else $error("end token with nonzero length");

  // The hex flag belongs to number and error tokens only.
  a_hex_kind: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[4]) |->
      (m_axis_tuser[3:0] == K_NUMBER || m_axis_tuser[3:0] == K_ERROR))
    else $error("hex flag on a non-number token");

  // Back-pressure on the input only arises from tokens waiting on the output.
  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with nothing to send");

endmodule : assembly_source_tokenizer_core
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the assembly source tokenizer core.
//
// Source texts are streamed into the core one byte per word. A scoreboard
// class keeps its own lexer state and works out every token each accepted
// byte should produce. Each token word that leaves the core is compared,
// field by field, with the oldest expected token. The run starts with short
// hand-written texts covering every token kind and the bad-digit and
// final-byte cases. Random texts follow, with idle cycles and stalls on
// both sides, one long receiver stall and sender pauses.
// ----------------------------------------------------------------------------
module tb_top;
  import ast_pkg::*;

  localparam int CYCLE_LIMIT = 20000;
  localparam int MAX_REPORTS = 40;
  localparam int RANDOM_BYTES = 140;
  localparam logic [15:0] COUNT_TOP  = 16'hFFFF;
  localparam logic [19:0] OFFSET_TOP = 20'hFFFFF;

  typedef enum logic [2:0] {
    SM_IDLE, SM_COMMENT, SM_ZERO, SM_DEC, SM_HEX, SM_IDENT, SM_DROP
  } scan_state_t;

  typedef struct {
    kind_t       kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [19:0] offset;
    logic [15:0] length;
    logic        hex;
    logic        last;
  } lexeme_t;

  class token_scoreboard;
    scan_state_t mode;
    logic [15:0] line_no, col_no, tok_line, tok_col, tok_len;
    logic [19:0] offs, tok_offs;
    lexeme_t     step_tokens[$];
    lexeme_t     pending_tokens[$];
    int          mismatches;
    int          tokens_seen;

    function new();
      mismatches = 0;
      tokens_seen = 0;
      restart();
    endfunction

    function void restart();
      mode = SM_IDLE;
      line_no = 16'd1;
      col_no = 16'd1;
      offs = 20'd0;
      tok_line = 16'd1;
      tok_col = 16'd1;
      tok_offs = 20'd0;
      tok_len = 16'd0;
    endfunction

    function logic [15:0] bump_count(logic [15:0] v);
      return (v == COUNT_TOP) ? v : v + 16'd1;
    endfunction

    function logic [19:0] bump_offset(logic [19:0] v);
      return (v == OFFSET_TOP) ? v : v + 20'd1;
    endfunction

    function bit is_dec(logic [7:0] c);
      return c >= CH_DIGIT0 && c <= CH_DIGIT9;
    endfunction

    function bit is_hex(logic [7:0] c);
      return is_dec(c) || (c >= CH_LOWERA && c <= CH_LOWERF) ||
             (c >= CH_UPPERA && c <= CH_UPPERF);
    endfunction

    function bit ends_number(logic [7:0] c);
      return c == CH_SPACE || c == CH_NL || c == CH_CR || c == CH_COLON ||
             c == CH_COMMA || c == CH_SEMI || c == CH_RBRACK;
    endfunction

    function bit ends_ident(logic [7:0] c);
      return ends_number(c) || c == CH_TAB || c == CH_LBRACK;
    endfunction

    function void emit(kind_t k, logic [15:0] ln, logic [15:0] cl, logic [19:0] off,
                       logic [15:0] len, logic hx);
      lexeme_t t;
      if (step_tokens.size() < 3) begin
        t.kind = k;
        t.line = ln;
        t.column = cl;
        t.offset = off;
        t.length = len;
        t.hex = hx;
        t.last = 1'b0;
        step_tokens.insert(step_tokens.size(), t);
      end
    endfunction

    function void emit_open(kind_t k, logic hx);
      emit(k, tok_line, tok_col, tok_offs, tok_len, hx);
    endfunction

    function void step_over();
      offs = bump_offset(offs);
      col_no = bump_count(col_no);
    endfunction

    function void open_token(scan_state_t m);
      tok_line = line_no;
      tok_col = col_no;
      tok_offs = offs;
      tok_len = 16'd1;
      mode = m;
      step_over();
    endfunction

    function void idle_byte(logic [7:0] c);
      mode = SM_IDLE;
      case (c)
        CH_NL: begin
          emit(K_NEWLINE, line_no, col_no, offs, 16'd1, 1'b0);
          offs = bump_offset(offs);
          line_no = bump_count(line_no);
          col_no = 16'd1;
        end
        CH_CR: offs = bump_offset(offs);
        CH_SPACE, CH_TAB: step_over();
        CH_SEMI: begin
          mode = SM_COMMENT;
          step_over();
        end
        CH_COMMA: begin
          emit(K_COMMA, line_no, col_no, offs, 16'd1, 1'b0);
          step_over();
        end
        CH_COLON: begin
          emit(K_COLON, line_no, col_no, offs, 16'd1, 1'b0);
          step_over();
        end
        CH_LBRACK: begin
          emit(K_LBRACKET, line_no, col_no, offs, 16'd1, 1'b0);
          step_over();
        end
        CH_RBRACK: begin
          emit(K_RBRACKET, line_no, col_no, offs, 16'd1, 1'b0);
          step_over();
        end
        default: begin
          if (is_dec(c)) open_token(c == CH_DIGIT0 ? SM_ZERO : SM_DEC);
          else open_token(SM_IDENT);
        end
      endcase
    endfunction

    function void note_byte(logic [7:0] c, logic fin);
      bit      errored;
      lexeme_t t;
      errored = 1'b0;
      step_tokens.delete();
      case (mode)
        SM_COMMENT: begin
          if (c == CH_NL) idle_byte(c);
          else step_over();
        end
        SM_ZERO, SM_DEC, SM_HEX: begin
          if (ends_number(c)) begin
            emit_open(K_NUMBER, mode == SM_HEX);
            idle_byte(c);
          end else if (mode == SM_ZERO && c == CH_LOWERX && !fin) begin
            tok_len = bump_count(tok_len);
            mode = SM_HEX;
            step_over();
          end else if (mode == SM_HEX ? is_hex(c) : is_dec(c)) begin
            tok_len = bump_count(tok_len);
            if (mode == SM_ZERO) mode = SM_DEC;
            step_over();
          end else begin
            tok_len = bump_count(tok_len);
            emit_open(K_ERROR, mode == SM_HEX);
            mode = SM_DROP;
            errored = 1'b1;
          end
        end
        SM_IDENT: begin
          if (ends_ident(c)) begin
            emit_open(K_IDENT, 1'b0);
            idle_byte(c);
          end else begin
            tok_len = bump_count(tok_len);
            step_over();
          end
        end
        SM_DROP: ;
        default: idle_byte(c);
      endcase
      if (fin) begin
        if (!errored && mode != SM_DROP) begin
          if (mode == SM_ZERO || mode == SM_DEC || mode == SM_HEX)
            emit_open(K_NUMBER, mode == SM_HEX);
          else if (mode == SM_IDENT)
            emit_open(K_IDENT, 1'b0);
          emit(K_END, line_no, col_no, offs, 16'd0, 1'b0);
        end
        restart();
      end
      foreach (step_tokens[i]) begin
        t = step_tokens[i];
        t.last = (i == step_tokens.size() - 1);
        pending_tokens.insert(pending_tokens.size(), t);
      end
    endfunction

    function void report(string field, longint want, longint got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: token %0d %s mismatch, expected %0d, actual %0d",
                 $time, tokens_seen, field, want, got);
    endfunction

    function void check_token(logic [71:0] data, logic [4:0] user, logic last);
      lexeme_t e;
      tokens_seen++;
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: token %0d unexpected, expected none, actual kind %0d",
                   $time, tokens_seen, user[3:0]);
        return;
      end
      e = pending_tokens.pop_front();
      if (user[3:0] !== e.kind) report("kind", e.kind, user[3:0]);
      if (data[15:0] !== e.line) report("line", e.line, data[15:0]);
      if (data[31:16] !== e.column) report("column", e.column, data[31:16]);
      if (data[51:32] !== e.offset) report("offset", e.offset, data[51:32]);
      if (data[67:52] !== e.length) report("length", e.length, data[67:52]);
      if (user[4] !== e.hex) report("hex flag", e.hex, user[4]);
      if (last !== e.last) report("last flag", e.last, last);
    endfunction

    function int outstanding();
      return pending_tokens.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;
  logic        m_axis_tlast;

  token_scoreboard sb = new();

  logic [7:0] text_bytes[$];
  bit         tx_quiet = 1'b0;
  bit         rx_quiet = 1'b0;
  int         rx_hold_request = 0;
  int         rx_hold_left = 0;
  int         cycles = 0;
  int         bytes_accepted = 0;
  int         texts_sent = 0;
  int         random_bytes = 0;

  assembly_source_tokenizer_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_byte(s_axis_tdata, s_axis_tlast);
        bytes_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready)
        sb.check_token(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d tokens outstanding",
               cycles, sb.outstanding());
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rx_hold_request > 0) begin
      rx_hold_left = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rx_quiet || ($urandom_range(0, 99) >= 18);
    end
  end

  // Called and returning at a falling edge, so back-to-back words keep
  // tvalid high without a gap.
  task automatic send_byte(logic [7:0] c, logic fin);
    while (!tx_quiet && $urandom_range(0, 99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text();
    foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
    text_bytes.delete();
    texts_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  function automatic void add_byte(logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 53);
    if (r < 26) return 8'(CH_LOWERA + r);
    if (r < 52) return 8'(CH_UPPERA + (r - 26));
    return (r == 52) ? 8'h5F : 8'h2E;
  endfunction

  function automatic logic [7:0] pick_hex_digit();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'(CH_DIGIT0 + r);
    if (r < 16) return 8'(CH_LOWERA + (r - 10));
    return 8'(CH_UPPERA + (r - 16));
  endfunction

  function automatic void add_separator();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: add_byte(CH_SPACE);
      5: add_byte(CH_COMMA);
      6: add_byte(CH_COLON);
      7: add_byte(CH_RBRACK);
      8: add_byte(CH_NL);
      default: ;
    endcase
  endfunction

  function automatic void add_piece();
    int         pick;
    int         n;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      add_byte(pick_letter());
      n = $urandom_range(0, 5);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) add_byte(8'(CH_DIGIT0 + $urandom_range(0, 9)));
        else add_byte(pick_letter());
      end
      add_separator();
    end else if (pick < 32) begin
      n = $urandom_range(1, 5);
      repeat (n) add_byte(8'(CH_DIGIT0 + $urandom_range(0, 9)));
      add_separator();
    end else if (pick < 42) begin
      add_byte(CH_DIGIT0);
      add_byte(CH_LOWERX);
      n = $urandom_range(1, 4);
      repeat (n) add_byte(pick_hex_digit());
      add_separator();
    end else if (pick < 47) begin
      add_byte(CH_DIGIT0);
      add_separator();
    end else if (pick < 60) begin
      case ($urandom_range(0, 3))
        0: add_byte(CH_COMMA);
        1: add_byte(CH_COLON);
        2: add_byte(CH_LBRACK);
        default: add_byte(CH_RBRACK);
      endcase
    end else if (pick < 72) begin
      n = $urandom_range(1, 3);
      repeat (n) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    end else if (pick < 78) begin
      add_byte(CH_SEMI);
      n = $urandom_range(0, 6);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        add_byte(b == CH_NL ? CH_SEMI : b);
      end
    end else if (pick < 90) begin
      if ($urandom_range(0, 2) == 0) add_byte(CH_CR);
      add_byte(CH_NL);
    end else begin
      add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Labels, hex and decimal operands, brackets, CR LF and a comment.
    add_str("ab:");
    add_byte(CH_TAB);
    add_str("0xAf,[7]");
    add_byte(CH_CR);
    add_byte(CH_NL);
    add_str(";c");
    add_byte(CH_NL);
    send_text();
    // An x after a leading zero as the final byte is a bad decimal digit.
    add_str("0x");
    send_text();
    // A tab inside a number is a bad digit; the rest of the text is dropped.
    add_str("1");
    add_byte(CH_TAB);
    add_str("2");
    send_text();
    add_str("0xg");
    send_text();
    // The final byte closes an open comment.
    add_byte(CH_SEMI);
    add_byte(8'hFF);
    send_text();
    add_byte(8'h80);
    add_byte(CH_LBRACK);
    add_byte(8'h00);
    send_text();
    add_str("0x1");
    send_text();
    wait_drained();

    while (random_bytes < RANDOM_BYTES) begin
      if (texts_sent == 7) begin
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
      end
      if (texts_sent == 8) begin
        // Receiver stalls while the sender keeps offering comma-heavy text.
        rx_hold_request = 300;
        repeat (30) add_byte(CH_COMMA);
      end
      repeat ($urandom_range(4, 14)) add_piece();
      random_bytes += text_bytes.size();
      send_text();
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      if (texts_sent % 5 == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(negedge clk);
    $display("Ran %0d texts, %0d bytes accepted, %0d tokens checked.",
             texts_sent, bytes_accepted, sb.tokens_seen);
    $display("Covered all token kinds, bad digits, final-byte flushes and stalls.");
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d expected tokens never arrived",
               sb.mismatches, sb.outstanding());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ast_pkg.sv
hdl/ast_front.sv
hdl/ast_queue.sv
hdl/ast_back.sv
hdl/assembly_source_tokenizer_core.sv
sim/tb_top.sv
